// ===== rtl/v3n_pkg.sv =====
package v3n_pkg;

  typedef struct packed {
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;
  } operand_t;

  typedef struct packed {
    logic        [15:0] length;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic               zero_vector;
  } result_t;

  localparam int FieldWidth = 16;

endpackage

// ===== rtl/v3n_sqrt_cell.sv =====
module v3n_sqrt_cell #(
  parameter int LW     = 17,
  parameter int SIDE_W = 51
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  logic [LW:0]       rem_in,
  input  logic [LW-1:0]     root_in,
  input  logic [2*LW-1:0]   rad_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [LW:0]       rem_out,
  output logic [LW-1:0]     root_out,
  output logic [2*LW-1:0]   rad_out,
  output logic [SIDE_W-1:0] side_out
);

  logic [LW+2:0] rem_shift;
  logic [LW+2:0] trial;
  logic          take;
  logic [LW+2:0] rem_diff;

  always_comb begin
    rem_shift = {rem_in, rad_in[2*LW-1:2*LW-2]};
    trial     = {1'b0, root_in, 2'b01};
    take      = rem_shift >= trial;
    rem_diff  = take ? (rem_shift - trial) : rem_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    rem_out  <= rem_diff[LW:0];
    root_out <= {root_in[LW-2:0], take};
    rad_out  <= {rad_in[2*LW-3:0], 2'b00};
    side_out <= side_in;
  end

endmodule

// ===== rtl/v3n_div_cell.sv =====
module v3n_div_cell #(
  parameter int LW = 17,
  parameter int FB = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  logic [LW-1:0]        len_in,
  input  logic [2:0]           sign_in,
  input  logic [2:0][LW-1:0]   rem_in,
  input  logic [2:0][FB:0]     feed_in,
  input  logic [2:0][FB:0]     quot_in,
  output logic                 valid_out,
  output logic [LW-1:0]        len_out,
  output logic [2:0]           sign_out,
  output logic [2:0][LW-1:0]   rem_out,
  output logic [2:0][FB:0]     feed_out,
  output logic [2:0][FB:0]     quot_out
);

  logic [2:0][LW:0]   rem_shift;
  logic [2:0]         take;
  logic [2:0][LW:0]   rem_diff;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_shift[i] = {rem_in[i], feed_in[i][FB]};
      take[i]      = rem_shift[i] >= {1'b0, len_in};
      rem_diff[i]  = take[i] ? (rem_shift[i] - {1'b0, len_in}) : rem_shift[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    len_out  <= len_in;
    sign_out <= sign_in;
    for (int i = 0; i < 3; i++) begin
      rem_out[i]  <= rem_diff[i][LW-1:0];
      feed_out[i] <= {feed_in[i][FB-1:0], 1'b0};
      quot_out[i] <= {quot_in[i][FB-1:0], take[i]};
    end
  end

endmodule

// ===== rtl/vector3_normalize.sv =====
// Throughput: one transfer per cycle; busy stays low, start may be high every cycle.
// The square root takes one cell per root bit, the division one cell per quotient bit.
// Reset (rst, synchronous) clears the valid chain; no result strobes until refilled.
// The receiver cannot stall: each result shows for exactly one cycle with done.
module vector3_normalize #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  v3n_pkg::operand_t  operand,
  output logic               done,
  output v3n_pkg::result_t   result
);

  localparam int CW     = COMPONENT_WIDTH;
  localparam int FB     = FRACTION_BITS;
  localparam int LW     = CW + 1;
  localparam int SW     = 2 * LW;
  localparam int SIDE_W = 3 + 3 * CW;
  localparam int UW     = FB + 2;
  localparam int OW     = (UW > 16) ? UW : 16;
  localparam int FW     = v3n_pkg::FieldWidth;

  logic [2:0][FW-1:0] field;
  logic [2:0][CW-1:0] raw;
  logic [2:0][CW-1:0] mag_in;
  logic [2:0]         neg_in;

  assign busy  = 1'b0;
  assign field = {operand.comp_x, operand.comp_y, operand.comp_z};

  generate
    if (CW <= FW) begin : g_narrow
      always_comb begin
        for (int i = 0; i < 3; i++) raw[i] = field[i][CW-1:0];
      end
    end else begin : g_wide
      always_comb begin
        for (int i = 0; i < 3; i++) raw[i] = CW'(field[i]);
      end
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = raw[i][CW-1];
      mag_in[i] = neg_in[i] ? (~raw[i] + 1'b1) : raw[i];
    end
  end

  logic               v0, v1, v2;
  logic [2:0][CW-1:0] mag0, mag1, mag2;
  logic [2:0]         neg0, neg1, neg2;
  logic [2:0][2*CW-1:0] sq1;
  logic [SW-1:0]      sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= start;
      v1 <= v0;
      v2 <= v1;
    end
    mag0 <= mag_in;
    neg0 <= neg_in;
    for (int i = 0; i < 3; i++) sq1[i] <= mag0[i] * mag0[i];
    mag1 <= mag0;
    neg1 <= neg0;
    sum2 <= SW'(sq1[0]) + SW'(sq1[1]) + SW'(sq1[2]);
    mag2 <= mag1;
    neg2 <= neg1;
  end

  logic [LW:0]              sv;
  logic [LW:0][LW:0]        srem;
  logic [LW:0][LW-1:0]      sroot;
  logic [LW:0][SW-1:0]      srad;
  logic [LW:0][SIDE_W-1:0]  sside;

  assign sv[0]    = v2;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = sum2;
  assign sside[0] = {neg2, mag2};

  generate
    for (genvar k = 0; k < LW; k++) begin : g_sqrt
      v3n_sqrt_cell #(.LW(LW), .SIDE_W(SIDE_W)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .valid_in  (sv[k]),
        .rem_in    (srem[k]),
        .root_in   (sroot[k]),
        .rad_in    (srad[k]),
        .side_in   (sside[k]),
        .valid_out (sv[k+1]),
        .rem_out   (srem[k+1]),
        .root_out  (sroot[k+1]),
        .rad_out   (srad[k+1]),
        .side_out  (sside[k+1])
      );
    end
  endgenerate

  logic [2:0][CW-1:0] smag;
  logic [2:0]         sneg;
  assign {sneg, smag} = sside[LW];

  logic [FB+1:0]                 dv;
  logic [FB+1:0][LW-1:0]         dlen;
  logic [FB+1:0][2:0]            dsign;
  logic [FB+1:0][2:0][LW-1:0]    drem;
  logic [FB+1:0][2:0][FB:0]      dfeed;
  logic [FB+1:0][2:0][FB:0]      dquot;

  assign dv[0]    = sv[LW];
  assign dlen[0]  = sroot[LW];
  assign dsign[0] = sneg;
  assign dquot[0] = '0;

  generate
    for (genvar i = 0; i < 3; i++) begin : g_feed
      assign drem[0][i]  = LW'(smag[i] >> 1);
      assign dfeed[0][i] = {smag[i][0], {FB{1'b0}}};
    end
  endgenerate

  generate
    for (genvar k = 0; k <= FB; k++) begin : g_div
      v3n_div_cell #(.LW(LW), .FB(FB)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .valid_in  (dv[k]),
        .len_in    (dlen[k]),
        .sign_in   (dsign[k]),
        .rem_in    (drem[k]),
        .feed_in   (dfeed[k]),
        .quot_in   (dquot[k]),
        .valid_out (dv[k+1]),
        .len_out   (dlen[k+1]),
        .sign_out  (dsign[k+1]),
        .rem_out   (drem[k+1]),
        .feed_out  (dfeed[k+1]),
        .quot_out  (dquot[k+1])
      );
    end
  endgenerate

  logic [LW-1:0]            flen;
  logic                     fzero;
  logic [2:0][UW-1:0]       fq;
  logic [2:0][UW-1:0]       fs;
  logic [2:0][OW-1:0]       fx;
  v3n_pkg::result_t         result_next;

  always_comb begin
    flen  = dlen[FB+1];
    fzero = (flen == '0);
    for (int i = 0; i < 3; i++) begin
      fq[i] = {1'b0, dquot[FB+1][i]};
      if (fq[i] > (UW'(1) << FB)) fq[i] = UW'(1) << FB;
      fs[i] = dsign[FB+1][i] ? (~fq[i] + 1'b1) : fq[i];
      fx[i] = OW'(signed'(fs[i]));
      if (fzero) fx[i] = '0;
    end
    result_next.length      = 16'(flen);
    result_next.unit_x      = fx[2][15:0];
    result_next.unit_y      = fx[1][15:0];
    result_next.unit_z      = fx[0][15:0];
    result_next.zero_vector = fzero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[FB+1];
    end
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_zero_units : assert property (@(posedge clk) disable iff (rst)
    done && result.zero_vector |->
      result.unit_x == 16'sd0 && result.unit_y == 16'sd0 && result.unit_z == 16'sd0)
    else $error("zero vector with nonzero unit components");

  a_zero_len : assert property (@(posedge clk) disable iff (rst)
    done && result.zero_vector |-> result.length == 16'd0)
    else $error("zero vector with nonzero length");

  a_done_idle : assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");
`endif

endmodule
